// File: src/fixed_point_alu_q24_8_defines.svh
// Assertion macros shared by the fixed-point ALU RTL.
// Depends on nothing; the including module supplies clk and rst.
`ifndef FIXED_POINT_ALU_Q24_8_DEFINES_SVH
`define FIXED_POINT_ALU_Q24_8_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FPALU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FPALU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/fpalu_pkg.sv
// Types, opcodes and saturation helpers for the fixed-point ALU.
// Depends on nothing; used by fixed_point_alu_q24_8 and its test bench.
`default_nettype none

package fpalu_pkg;

  typedef enum logic [3:0] {
    KIND_ADD = 4'd0,
    KIND_SUB = 4'd1,
    KIND_MUL = 4'd2,
    KIND_DIV = 4'd3,
    KIND_MIN = 4'd4,
    KIND_MAX = 4'd5,
    KIND_CMP = 4'd6,
    KIND_INC = 4'd7,
    KIND_DEC = 4'd8
  } kind_t;

  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [3:0]         kind;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               is_greater;
    logic               is_less;
    logic               is_greater_equal;
    logic               is_less_equal;
    logic               is_equal;
    logic               is_not_equal;
    logic               overflow;
    logic               divide_by_zero;
  } rsp_t;

  // Clamp a 33-bit signed sum; returns {overflow, result}.
  function automatic logic [32:0] sat_sum(input logic [32:0] v);
    logic ovf;
    ovf = v[32] != v[31];
    if (ovf) begin
      sat_sum = {1'b1, (v[32] ? NEG_MIN : POS_MAX)};
    end else begin
      sat_sum = {1'b0, v[31:0]};
    end
  endfunction

  // Apply a sign to a magnitude and clamp; returns {overflow, result}.
  function automatic logic [32:0] sat_mag(input logic neg, input logic [64:0] mag);
    if (neg) begin
      if (mag > 65'h0_8000_0000) begin
        sat_mag = {1'b1, NEG_MIN};
      end else begin
        sat_mag = {1'b0, (~mag[31:0]) + 32'd1};
      end
    end else begin
      if (mag > 65'h0_7FFF_FFFF) begin
        sat_mag = {1'b1, POS_MAX};
      end else begin
        sat_mag = {1'b0, mag[31:0]};
      end
    end
  endfunction

endpackage

`default_nettype wire

// File: src/fpalu_div.sv
// Pipelined restoring divider: one quotient bit per stage, round half up.
// Depends on nothing else; the rounded quotient is registered after the last stage.
`default_nettype none

module fpalu_div #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic                    clk,
  input  wire logic [31:0]             num_mag,
  input  wire logic [31:0]             den,
  output logic      [32+FRAC_BITS:0]   quot
);

  localparam int QW = 32 + FRAC_BITS;

  logic [31:0]   rem_q  [QW+1];
  logic [QW-1:0] work_q [QW+1];
  logic [31:0]   den_q  [QW+1];

  assign rem_q[0]  = 32'd0;
  assign work_q[0] = QW'(num_mag) << FRAC_BITS;
  assign den_q[0]  = den;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [32:0] trial;
    logic        fits;
    assign trial = {rem_q[s], work_q[s][QW-1]};
    assign fits  = trial >= {1'b0, den_q[s]};
    always_ff @(posedge clk) begin
      rem_q[s+1]  <= fits ? 32'(trial - {1'b0, den_q[s]}) : trial[31:0];
      work_q[s+1] <= {work_q[s][QW-2:0], fits};
      den_q[s+1]  <= den_q[s];
    end
  end

  logic rnd;
  assign rnd = {rem_q[QW], 1'b0} >= {1'b0, den_q[QW]};

  always_ff @(posedge clk) begin
    quot <= (QW+1)'(work_q[QW]) + (QW+1)'(rnd);
  end

endmodule

`default_nettype wire

// File: src/fixed_point_alu_q24_8.sv
// Channel   Ports               Beat
// command   start, busy, cmd    accepted when start is high and busy is low
// response  done, rsp           one cycle per result, always taken
//
// One command enters every cycle while busy is low; each result passes stages A to E in turn.
// The delay line after stage D matches the divider, which resolves one quotient bit per stage.
// All opcodes take the same path through the delay line, so results leave in command order.
// Synchronous reset clears the valid bits; busy is high only during reset.
// Top level of the fixed-point ALU; depends on fpalu_pkg, fpalu_div and the defines header.
`default_nettype none
`include "fixed_point_alu_q24_8_defines.svh"

module fixed_point_alu_q24_8 #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire fpalu_pkg::cmd_t  cmd,
  output logic                  done,
  output fpalu_pkg::rsp_t       rsp
);

  localparam int QW  = 32 + FRAC_BITS;
  localparam int DLY = QW;

  typedef struct packed {
    fpalu_pkg::rsp_t rsp;
    logic            is_div;
    logic            neg;
    logic            dz;
  } dly_t;

  assign busy = rst;

  // Stage A: command register.
  logic            vld_a;
  fpalu_pkg::cmd_t a_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else begin
      vld_a <= start && !busy;
    end
    a_cmd <= cmd;
  end

  // Stage B: magnitudes and sign.
  logic               vld_b;
  logic [3:0]         b_kind;
  logic signed [31:0] b_a;
  logic signed [31:0] b_b;
  logic [31:0]        b_mag_a;
  logic [31:0]        b_mag_b;
  logic               b_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_b <= 1'b0;
    end else begin
      vld_b <= vld_a;
    end
    b_kind  <= a_cmd.kind;
    b_a     <= a_cmd.operand_a;
    b_b     <= a_cmd.operand_b;
    b_mag_a <= a_cmd.operand_a[31] ? (~a_cmd.operand_a) + 32'd1 : a_cmd.operand_a;
    b_mag_b <= a_cmd.operand_b[31] ? (~a_cmd.operand_b) + 32'd1 : a_cmd.operand_b;
    b_neg   <= a_cmd.operand_a[31] != a_cmd.operand_b[31];
  end

  // Stage C: simple operations and the magnitude product.
  logic [32:0]     ext_a;
  logic [32:0]     ext_b;
  logic            a_gt;
  logic            a_lt;
  logic            a_eq;
  logic [32:0]     sat_v;
  fpalu_pkg::rsp_t c_rsp_next;

  assign ext_a = {b_a[31], b_a};
  assign ext_b = {b_b[31], b_b};
  assign a_gt  = b_a > b_b;
  assign a_lt  = b_a < b_b;
  assign a_eq  = b_a == b_b;

  always_comb begin
    c_rsp_next = '0;
    sat_v      = '0;
    case (b_kind)
      fpalu_pkg::KIND_ADD: sat_v = fpalu_pkg::sat_sum(ext_a + ext_b);
      fpalu_pkg::KIND_SUB: sat_v = fpalu_pkg::sat_sum(ext_a - ext_b);
      fpalu_pkg::KIND_INC: sat_v = fpalu_pkg::sat_sum(ext_a + 33'd1);
      fpalu_pkg::KIND_DEC: sat_v = fpalu_pkg::sat_sum(ext_a - 33'd1);
      fpalu_pkg::KIND_MIN: sat_v = {1'b0, (a_lt ? b_a : b_b)};
      fpalu_pkg::KIND_MAX: sat_v = {1'b0, (a_gt ? b_a : b_b)};
      default:             sat_v = '0;
    endcase
    c_rsp_next.result   = sat_v[31:0];
    c_rsp_next.overflow = sat_v[32];
    if (b_kind == fpalu_pkg::KIND_CMP) begin
      c_rsp_next.is_greater       = a_gt;
      c_rsp_next.is_less          = a_lt;
      c_rsp_next.is_greater_equal = !a_lt;
      c_rsp_next.is_less_equal    = !a_gt;
      c_rsp_next.is_equal         = a_eq;
      c_rsp_next.is_not_equal     = !a_eq;
    end
  end

  logic            vld_c;
  logic [3:0]      c_kind;
  fpalu_pkg::rsp_t c_rsp;
  logic [63:0]     c_prod;
  logic            c_neg;
  logic            c_dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_c <= 1'b0;
    end else begin
      vld_c <= vld_b;
    end
    c_kind <= b_kind;
    c_rsp  <= c_rsp_next;
    c_prod <= b_mag_a * b_mag_b;
    c_neg  <= b_neg;
    c_dz   <= b_mag_b == 32'd0;
  end

  // Divider runs from stage B in parallel with C and D.
  logic [QW:0] div_q;

  fpalu_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .num_mag (b_mag_a),
    .den     (b_mag_b),
    .quot    (div_q)
  );

  // Stage D: round and clamp the product.
  localparam logic [64:0] MUL_RND = (65'd1 << FRAC_BITS) >> 1;

  logic [64:0] mul_q;
  logic [32:0] mul_sat;
  dly_t        d_next;

  assign mul_q   = ({1'b0, c_prod} + MUL_RND) >> FRAC_BITS;
  assign mul_sat = fpalu_pkg::sat_mag(c_neg, mul_q);

  always_comb begin
    d_next        = '0;
    d_next.rsp    = c_rsp;
    d_next.is_div = c_kind == fpalu_pkg::KIND_DIV;
    d_next.neg    = c_neg;
    d_next.dz     = c_dz;
    if (c_kind == fpalu_pkg::KIND_MUL) begin
      d_next.rsp.result   = mul_sat[31:0];
      d_next.rsp.overflow = mul_sat[32];
    end
  end

  logic [DLY-1:0] vld_d;
  dly_t           dly [DLY];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_d <= '0;
    end else begin
      vld_d <= {vld_d[DLY-2:0], vld_c};
    end
    dly[0] <= d_next;
    for (int k = 1; k < DLY; k++) begin
      dly[k] <= dly[k-1];
    end
  end

  // Stage E: merge the quotient and drive the response.
  dly_t            tail;
  logic [32:0]     div_sat;
  fpalu_pkg::rsp_t rsp_next;

  assign tail    = dly[DLY-1];
  assign div_sat = fpalu_pkg::sat_mag(tail.neg, 65'(div_q));

  always_comb begin
    rsp_next = tail.rsp;
    if (tail.is_div) begin
      rsp_next = '0;
      if (tail.dz) begin
        rsp_next.divide_by_zero = 1'b1;
      end else begin
        rsp_next.result   = div_sat[31:0];
        rsp_next.overflow = div_sat[32];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_d[DLY-1];
    end
    rsp <= rsp_next;
  end

  `FPALU_ASSERT_NOW(a_flags_excl, done, !(rsp.overflow && rsp.divide_by_zero), "overflow with divide by zero")
  `FPALU_ASSERT_NOW(a_gt_cons, done && rsp.is_greater, rsp.is_greater_equal && rsp.is_not_equal && !rsp.is_less_equal, "inconsistent compare flags")
  `FPALU_ASSERT_NEXT(a_vld_b, vld_a, vld_b, "beat lost between stages A and B")
  `FPALU_ASSERT_NOW(a_cmp_zero, done && rsp.is_equal, rsp.result == 32'sd0, "compare result not zero")

endmodule

`default_nettype wire

// File: dv/fixed_point_alu_q24_8_test.sv
// Self-checking bench for the fixed-point ALU: random and directed commands,
// each result predicted in the bench and compared as a whole response, in order.
// Depends on fpalu_pkg and the fixed_point_alu_q24_8 RTL.
`timescale 1ns / 100ps

module fixed_point_alu_q24_8_test;

  localparam int FRAC = 8;
  localparam int LATENCY = 35 + FRAC;
  localparam int WATCHDOG = 20000;
  localparam int N_RANDOM = 1330;

  class alu_scoreboard;
    fpalu_pkg::rsp_t pending[$];
    int mismatches;

    function fpalu_pkg::rsp_t predict(fpalu_pkg::cmd_t c);
      fpalu_pkg::rsp_t r;
      longint a, b, v, lim_hi, lim_lo;
      longint unsigned ma, mb, m, q, n, rem;
      bit neg;
      r = '0;
      a = c.operand_a;
      b = c.operand_b;
      lim_hi = 64'sh7FFF_FFFF;
      lim_lo = -64'sh8000_0000;
      v = 0;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      neg = (a < 0) != (b < 0);
      case (c.kind)
        fpalu_pkg::KIND_ADD: v = a + b;
        fpalu_pkg::KIND_SUB: v = a - b;
        fpalu_pkg::KIND_INC: v = a + 1;
        fpalu_pkg::KIND_DEC: v = a - 1;
        fpalu_pkg::KIND_MUL, fpalu_pkg::KIND_DIV: begin
          if (c.kind == fpalu_pkg::KIND_DIV && b == 0) begin
            r.divide_by_zero = 1'b1;
            q = 0;
          end else if (c.kind == fpalu_pkg::KIND_MUL) begin
            m = ma * mb;
            q = (FRAC > 0) ? (m + (64'd1 << (FRAC - 1))) >> FRAC : m;
          end else begin
            n = ma << FRAC;
            q = n / mb;
            rem = n % mb;
            if (rem >= mb - rem) q++;
          end
          neg = neg && q != 0;
          if (neg) v = (q > 64'h8000_0000) ? lim_lo - 1 : -longint'(q);
          else v = (q > 64'h7FFF_FFFF) ? lim_hi + 1 : longint'(q);
        end
        fpalu_pkg::KIND_MIN: v = (a < b) ? a : b;
        fpalu_pkg::KIND_MAX: v = (a > b) ? a : b;
        fpalu_pkg::KIND_CMP: begin
          r.is_greater = a > b;
          r.is_less = a < b;
          r.is_greater_equal = a >= b;
          r.is_less_equal = a <= b;
          r.is_equal = a == b;
          r.is_not_equal = a != b;
        end
        default: v = 0;
      endcase
      if (v > lim_hi) begin
        v = lim_hi;
        r.overflow = 1'b1;
      end else if (v < lim_lo) begin
        v = lim_lo;
        r.overflow = 1'b1;
      end
      r.result = v[31:0];
      return r;
    endfunction

    function void note_command(fpalu_pkg::cmd_t c);
      pending.push_back(predict(c));
    endfunction

    function void check_result(fpalu_pkg::rsp_t got);
      fpalu_pkg::rsp_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected %h actual %h", want, got);
      end
    endfunction
  endclass

  logic clk, rst, start, busy, done;
  fpalu_pkg::cmd_t cmd;
  fpalu_pkg::rsp_t rsp;
  alu_scoreboard board;
  int idle_cycles;
  bit calm;

  fixed_point_alu_q24_8 #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .done(done), .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) board.note_command(cmd);
      if (done) board.check_result(rsp);
      if ((start && !busy) || done) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles > WATCHDOG) begin
        $display("fixed_point_alu_q24_8_test: FAIL");
        $finish;
      end
    end
  end

  task automatic send(input logic [3:0] k, input logic [31:0] a, input logic [31:0] b);
    while (!calm && $urandom_range(99) < 32) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    cmd <= '{kind: k, operand_a: a, operand_b: b};
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? fpalu_pkg::POS_MAX - $urandom_range(3)
                                  : fpalu_pkg::NEG_MIN + $urandom_range(3);
      1: return $signed($urandom_range(512)) - 256;
      2: return $signed($urandom_range(1 << 20)) - (1 << 19);
      3: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] x;
    board = new();
    idle_cycles = 0;
    calm = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send(fpalu_pkg::KIND_ADD, fpalu_pkg::POS_MAX, 32'd1);
    send(fpalu_pkg::KIND_ADD, fpalu_pkg::NEG_MIN, fpalu_pkg::NEG_MIN);
    send(fpalu_pkg::KIND_SUB, fpalu_pkg::NEG_MIN, 32'd1);
    send(fpalu_pkg::KIND_SUB, fpalu_pkg::POS_MAX, fpalu_pkg::NEG_MIN);
    send(fpalu_pkg::KIND_MUL, fpalu_pkg::POS_MAX, fpalu_pkg::POS_MAX);
    send(fpalu_pkg::KIND_MUL, fpalu_pkg::NEG_MIN, fpalu_pkg::POS_MAX);
    send(fpalu_pkg::KIND_MUL, 32'h0000_0180, 32'hFFFF_FF80);
    send(fpalu_pkg::KIND_MUL, 32'h0000_0001, 32'hFFFF_FF80);
    send(fpalu_pkg::KIND_DIV, 32'd100, 32'd0);
    send(fpalu_pkg::KIND_DIV, fpalu_pkg::NEG_MIN, 32'd1);
    send(fpalu_pkg::KIND_DIV, fpalu_pkg::NEG_MIN, 32'hFFFF_FFFF);
    send(fpalu_pkg::KIND_DIV, 32'd1, 32'd512);
    send(fpalu_pkg::KIND_DIV, 32'hFFFF_FFFF, 32'd512);
    send(fpalu_pkg::KIND_MIN, 32'd5, 32'd5);
    send(fpalu_pkg::KIND_MAX, fpalu_pkg::NEG_MIN, fpalu_pkg::POS_MAX);
    send(fpalu_pkg::KIND_CMP, 32'd7, 32'd7);
    send(fpalu_pkg::KIND_CMP, fpalu_pkg::NEG_MIN, fpalu_pkg::POS_MAX);
    send(fpalu_pkg::KIND_CMP, fpalu_pkg::POS_MAX, fpalu_pkg::NEG_MIN);
    send(fpalu_pkg::KIND_INC, fpalu_pkg::POS_MAX, 32'd0);
    send(fpalu_pkg::KIND_DEC, fpalu_pkg::NEG_MIN, 32'd0);
    send(4'd9, 32'd3, 32'd4);
    send(4'd15, fpalu_pkg::POS_MAX, fpalu_pkg::NEG_MIN);

    for (int i = 0; i < N_RANDOM; i++) begin
      calm = (i >= 400 && i < 650);
      x = pick_operand();
      send($urandom_range(99) < 4 ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8)),
           x, ($urandom_range(19) == 0) ? 32'd0 :
              ($urandom_range(9) == 0) ? x : pick_operand());
    end
    start <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("fixed_point_alu_q24_8_test: PASS");
    end else begin
      $display("fixed_point_alu_q24_8_test: FAIL");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+src
src/fpalu_pkg.sv
src/fpalu_div.sv
src/fixed_point_alu_q24_8.sv
dv/fixed_point_alu_q24_8_test.sv
